[design/evs_pkg.sv]
// Shared types, constants and helpers for the encoder velocity sampler.
package evs_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int POS_W        = 32;
  localparam int ELAPSED_W    = 16;
  localparam int CPR_W        = 16;
  localparam int PROD_W       = 48;
  localparam int DIV_W        = 16;

  localparam logic [9:0]  MS_PER_S       = 10'd1000;
  localparam logic [15:0] MILLIRPM_SCALE = 16'd60000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ZERO   = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                 opcode;
    logic                 channel;
    logic [POS_W-1:0]     position;
    logic [ELAPSED_W-1:0] interval;
  } in_t;

  typedef struct packed {
    logic                     channel_out;
    logic [POS_W-1:0]         position_out;
    logic signed [POS_W-1:0]  delta;
    logic signed [POS_W-1:0]  count_rate;
    logic signed [POS_W-1:0]  milli_rpm;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DELTA,
    ST_MUL1,
    ST_START1,
    ST_WAIT1,
    ST_SAT1,
    ST_MUL2,
    ST_START2,
    ST_WAIT2,
    ST_SAT2,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic upd_base;
    logic calc_delta;
    logic mul1;
    logic div_start;
    logic div_sel;
    logic sat1;
    logic mul2;
    logic sat2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_zero_op;
    logic in_range;
    logic div_done;
    logic out_free;
  } status_t;

  // Clip an unsigned quotient to the magnitude range of a signed 32-bit result.
  function automatic logic [POS_W-1:0] sat_mag(input logic [PROD_W-1:0] q, input logic neg);
    logic [PROD_W-1:0] lim;
    lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    return (q > lim) ? lim[POS_W-1:0] : q[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] apply_sign(input logic [POS_W-1:0] mag, input logic neg);
    return neg ? (~mag + 32'd1) : mag;
  endfunction

endpackage

[design/evs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module evs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [evs_pkg::PROD_W-1:0]  dividend,
  input  logic [evs_pkg::DIV_W-1:0]   divisor,
  output logic [evs_pkg::PROD_W-1:0]  quotient,
  output logic                        done
);
  import evs_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign done  = busy && (cnt == CNT_W'(PROD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      quotient <= {quotient[PROD_W-2:0], fits};
    end
  end

endmodule

[design/evs_dpath.sv]
// Datapath: input and baseline registers, scaling multipliers, divider, output register.
module evs_dpath #(
  parameter int CHANNELS = evs_pkg::CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  evs_pkg::in_t              in_data,
  input  logic                      cfg_we,
  input  logic [evs_pkg::CPR_W-1:0] cfg_data,
  output evs_pkg::out_t             out_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  evs_pkg::cmd_t             cmd,
  output evs_pkg::status_t          status
);
  import evs_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  in_t               in_q;
  logic [CPR_W-1:0]  counts_per_rev;
  logic [POS_W-1:0]  baseline [CHANNELS];
  logic [POS_W-1:0]  delta_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [POS_W-1:0]  cps_mag;
  logic [POS_W-1:0]  cps_q;
  logic [POS_W-1:0]  rpm_q;
  logic [POS_W-1:0]  delta_mag;
  logic [POS_W-1:0]  rpm_mag;
  logic [CH_W-1:0]   idx;
  logic [DIV_W-1:0]  divisor;
  logic [PROD_W-1:0] quotient;
  logic              div_done;

  assign idx       = CH_W'(in_q.channel);
  assign delta_mag = delta_q[POS_W-1] ? (~delta_q + 32'd1) : delta_q;
  assign rpm_mag   = sat_mag(quotient, neg_q);
  assign divisor   = cmd.div_sel ? counts_per_rev
                   : ((in_q.interval == '0) ? DIV_W'(1) : in_q.interval);

  evs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_q),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign status.is_zero_op = (in_q.opcode == OP_ZERO);
  assign status.in_range   = 32'(in_q.channel) < 32'(CHANNELS);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= '0;
    end else if (cfg_we) begin
      counts_per_rev <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        baseline[i] <= '0;
      end
    end else if (cmd.upd_base) begin
      baseline[idx] <= in_q.position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.calc_delta) begin
      delta_q <= in_q.position - baseline[idx];
    end
    if (cmd.mul1) begin
      neg_q  <= delta_q[POS_W-1];
      prod_q <= PROD_W'(delta_mag) * PROD_W'(MS_PER_S);
    end
    if (cmd.sat1) begin
      cps_mag <= sat_mag(quotient, neg_q);
      cps_q   <= apply_sign(sat_mag(quotient, neg_q), neg_q);
    end
    if (cmd.mul2) begin
      prod_q <= PROD_W'(cps_mag) * PROD_W'(MILLIRPM_SCALE);
    end
    if (cmd.sat2) begin
      rpm_q <= (counts_per_rev == '0) ? '0 : apply_sign(rpm_mag, neg_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.channel_out  <= in_q.channel;
      out_data.position_out <= in_q.position;
      out_data.delta        <= delta_q;
      out_data.count_rate   <= cps_q;
      out_data.milli_rpm    <= rpm_q;
    end
  end

endmodule

[design/evs_ctrl.sv]
// Controller state machine sequencing the sample computation.
module evs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  evs_pkg::status_t status,
  output evs_pkg::cmd_t    cmd
);
  import evs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status.in_range || status.is_zero_op) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DELTA;
        end
      end
      ST_DELTA:  state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_START1;
      ST_START1: state_next = ST_WAIT1;
      ST_WAIT1: begin
        if (status.div_done) state_next = ST_SAT1;
      end
      ST_SAT1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_START2;
      ST_START2: state_next = ST_WAIT2;
      ST_WAIT2: begin
        if (status.div_done) state_next = ST_SAT2;
      end
      ST_SAT2:   state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DECODE: begin
        cmd.upd_base = status.in_range && status.is_zero_op;
      end
      ST_DELTA: begin
        cmd.calc_delta = 1'b1;
        cmd.upd_base   = 1'b1;
      end
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_START1: cmd.div_start = 1'b1;
      ST_SAT1:   cmd.sat1 = 1'b1;
      ST_MUL2:   cmd.mul2 = 1'b1;
      ST_START2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      ST_WAIT2:  cmd.div_sel = 1'b1;
      ST_SAT2:   cmd.sat2 = 1'b1;
      ST_OUTPUT: cmd.load_out = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/encoder_velocity_sampler.sv]
// Encoder velocity sampler: per-channel delta, counts per second and milli-rpm.
// A sample transaction runs two passes of the shared bit-serial divider before its result
// shows; a zero or out-of-range transaction ends after decode without an output.
// A new transaction is taken only in idle, after the previous one has finished.
// Reset (synchronous, active high): baselines and counts_per_rev go to zero,
// the output register empties and the controller returns to idle.
module encoder_velocity_sampler #(
  parameter int CHANNELS = evs_pkg::CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  evs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output evs_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [evs_pkg::CPR_W-1:0] cfg_data
);
  import evs_pkg::*;

  cmd_t    cmd;
  status_t status;

  evs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  evs_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
